FILE: src/jsu_pkg.sv
// Package for the JSON string unescaper: payload types, status and kind
// codes, result-queue sizing and character-class helpers. No dependencies.
`default_nettype none

package jsu_pkg;

  // Input item: one raw byte of a string body
  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] string_kind;
    logic       starts_string;
    logic       end_of_input;
  } in_t;

  // Result item: one decoded byte or one status report
  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       run_end;
  } out_t;

  // Result status codes
  localparam logic [2:0] ST_DATA   = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_CTRL   = 3'd2;
  localparam logic [2:0] ST_BADHEX = 3'd3;
  localparam logic [2:0] ST_XESC   = 3'd4;
  localparam logic [2:0] ST_OCT    = 3'd5;
  localparam logic [2:0] ST_END    = 3'd6;

  // String kinds
  localparam logic [1:0] KIND_DQ  = 2'd0;
  localparam logic [1:0] KIND_SQ  = 2'd1;
  localparam logic [1:0] KIND_ID  = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  // Most results one input byte can cause (a three-byte UTF-8 sequence)
  localparam int MaxRes = 3;
  localparam int ResCntW = $clog2(MaxRes + 1);

  // Result queue sizing
  localparam int QDepth = MaxRes + 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // Results of one decode step, handed to the result queue
  typedef struct packed {
    logic [ResCntW-1:0]  cnt;
    out_t [MaxRes-1:0]   res;
  } push_t;

  // Hex digit test and value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - 8'h30)};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'h57)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // Letters, digits, underscore and dollar
  function automatic logic ident_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_" || c == "$";
  endfunction

endpackage

`default_nettype wire

FILE: src/jsu_decode.sv
// Escape decoder: per-byte state machine and UTF-8 encoder for \u escapes.
// Depends on jsu_pkg.
`default_nettype none

module jsu_decode (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire jsu_pkg::in_t item,
  output jsu_pkg::push_t    push
);

  localparam int ResCntW = jsu_pkg::ResCntW;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX0 = 3'd3,
    PH_HEX1 = 3'd4,
    PH_HEX2 = 3'd5,
    PH_HEX3 = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt, eff_phase;
  logic [1:0]  mode_r, mode_nxt, eff_mode;
  logic [11:0] acc_r, acc_nxt, eff_acc;
  logic [4:0]  hex;
  logic [15:0] code;
  logic [7:0]  b;
  logic [7:0]  term;
  jsu_pkg::push_t res;

  // Pack one result
  function automatic jsu_pkg::out_t mk(input logic [7:0] v, input logic [2:0] st);
    jsu_pkg::out_t o;
    o.out_byte = (st == jsu_pkg::ST_DATA) ? v : 8'd0;
    o.status   = st;
    o.run_end  = 1'b0;
    return o;
  endfunction

  // Decode one byte against the current phase
  always_comb begin
    b         = item.data_byte;
    eff_phase = phase_r;
    eff_mode  = mode_r;
    eff_acc   = acc_r;
    if (item.starts_string) begin
      eff_phase = PH_BODY;
      eff_mode  = (item.string_kind == jsu_pkg::KIND_BAD) ? jsu_pkg::KIND_DQ : item.string_kind;
      eff_acc   = 12'd0;
    end
    phase_nxt = eff_phase;
    mode_nxt  = eff_mode;
    acc_nxt   = eff_acc;
    hex       = jsu_pkg::hex_digit(b);
    code      = {eff_acc, hex[3:0]};
    term      = (eff_mode == jsu_pkg::KIND_SQ) ? 8'h27 : 8'h22;
    res.cnt   = '0;
    res.res   = '0;

    if (eff_phase == PH_IDLE) begin
      res.cnt = '0;
    end else if (item.end_of_input) begin
      res.res[0] = mk(8'd0, jsu_pkg::ST_END);
      res.cnt    = 2'd1;
      phase_nxt  = PH_IDLE;
    end else begin
      unique case (eff_phase)
        PH_BODY: begin
          res.cnt = 2'd1;
          if ((eff_mode == jsu_pkg::KIND_ID) ? !jsu_pkg::ident_char(b) : (b == term)) begin
            res.res[0] = mk(8'd0, jsu_pkg::ST_DONE);
            phase_nxt  = PH_IDLE;
          end else if (b <= 8'h1F) begin
            res.res[0] = mk(8'd0, jsu_pkg::ST_CTRL);
            phase_nxt  = PH_IDLE;
          end else if (b == 8'h5C) begin
            res.cnt   = '0;
            phase_nxt = PH_ESC;
          end else begin
            res.res[0] = mk(b, jsu_pkg::ST_DATA);
          end
        end
        PH_ESC: begin
          res.cnt   = 2'd1;
          phase_nxt = PH_BODY;
          case (b)
            "b": res.res[0] = mk(8'h08, jsu_pkg::ST_DATA);
            "f": res.res[0] = mk(8'h0C, jsu_pkg::ST_DATA);
            "n": res.res[0] = mk(8'h0A, jsu_pkg::ST_DATA);
            "r": res.res[0] = mk(8'h0D, jsu_pkg::ST_DATA);
            "t": res.res[0] = mk(8'h09, jsu_pkg::ST_DATA);
            "v": res.res[0] = mk(8'h0B, jsu_pkg::ST_DATA);
            "u": begin
              res.cnt   = '0;
              phase_nxt = PH_HEX0;
              acc_nxt   = 12'd0;
            end
            "x": begin
              res.res[0] = mk(8'd0, jsu_pkg::ST_XESC);
              phase_nxt  = PH_IDLE;
            end
            "0", "1", "2", "3", "4", "5", "6", "7": begin
              res.res[0] = mk(8'd0, jsu_pkg::ST_OCT);
              phase_nxt  = PH_IDLE;
            end
            default: res.res[0] = mk(b, jsu_pkg::ST_DATA);
          endcase
        end
        PH_HEX0, PH_HEX1, PH_HEX2: begin
          if (!hex[4]) begin
            res.res[0] = mk(8'd0, jsu_pkg::ST_BADHEX);
            res.cnt    = 2'd1;
            phase_nxt  = PH_IDLE;
          end else begin
            acc_nxt   = {eff_acc[7:0], hex[3:0]};
            phase_nxt = phase_t'(eff_phase + 3'd1);
          end
        end
        PH_HEX3: begin
          if (!hex[4]) begin
            res.res[0] = mk(8'd0, jsu_pkg::ST_BADHEX);
            res.cnt    = 2'd1;
            phase_nxt  = PH_IDLE;
          end else begin
            acc_nxt   = 12'd0;
            phase_nxt = PH_BODY;
            // Encode the code point as UTF-8
            if (code < 16'h0080) begin
              res.res[0] = mk(code[7:0], jsu_pkg::ST_DATA);
              res.cnt    = 2'd1;
            end else if (code < 16'h0800) begin
              res.res[0] = mk(8'hC0 | {3'd0, code[10:6]}, jsu_pkg::ST_DATA);
              res.res[1] = mk(8'h80 | {2'd0, code[5:0]}, jsu_pkg::ST_DATA);
              res.cnt    = 2'd2;
            end else begin
              res.res[0] = mk(8'hE0 | {4'd0, code[15:12]}, jsu_pkg::ST_DATA);
              res.res[1] = mk(8'h80 | {2'd0, code[11:6]}, jsu_pkg::ST_DATA);
              res.res[2] = mk(8'h80 | {2'd0, code[5:0]}, jsu_pkg::ST_DATA);
              res.cnt    = 2'd3;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          res.cnt   = '0;
        end
      endcase
    end

    // Flag the last result of this byte
    for (int i = 0; i < jsu_pkg::MaxRes; i++) begin
      if (res.cnt == ResCntW'(i + 1)) res.res[i].run_end = 1'b1;
    end
  end

  assign push.res = res.res;
  assign push.cnt = step ? res.cnt : '0;

  // Hold decoder state; advance on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      mode_r  <= jsu_pkg::KIND_DQ;
      acc_r   <= 12'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A status report always returns the decoder to idle
  a_fail_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && push.cnt == 2'd1 && push.res[0].status != jsu_pkg::ST_DATA)
    |=> phase_r == PH_IDLE)
    else $error("decoder not idle after status report");

  // Multi-byte output only comes from the last hex digit
  a_multi_hex: assert property (@(posedge clk) disable iff (!rst_n)
    (step && push.cnt > 2'd1) |=> (phase_r == PH_BODY && acc_r == 12'd0))
    else $error("multi-byte result outside a \\u escape");
`endif

endmodule

`default_nettype wire

FILE: src/jsu_out_queue.sv
// Result queue: takes up to three results per cycle from the decoder and
// hands them out one per transfer. Depends on jsu_pkg.
`default_nettype none

module jsu_out_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire jsu_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_stall,
  output jsu_pkg::out_t       out_data
);

  localparam int Depth = jsu_pkg::QDepth;
  localparam int CntW  = jsu_pkg::QCntW;
  localparam int MaxRes = jsu_pkg::MaxRes;

  jsu_pkg::out_t [Depth-1:0] q_r, q_nxt, shifted;
  logic [CntW-1:0] cnt_r, cnt_nxt, base, rel;
  logic            pop;

  assign out_valid = cnt_r != '0;
  assign out_data  = q_r[0];
  assign pop       = out_valid && !out_stall;
  // Room for a full burst of results
  assign room      = cnt_r <= CntW'(Depth - MaxRes);

  // Shift out the head, then append the new results behind the survivors
  always_comb begin
    base = cnt_r - {{(CntW-1){1'b0}}, pop};
    for (int i = 0; i < Depth - 1; i++) begin
      shifted[i] = pop ? q_r[i+1] : q_r[i];
    end
    shifted[Depth-1] = q_r[Depth-1];
    for (int i = 0; i < Depth; i++) begin
      rel      = CntW'(i) - base;
      q_nxt[i] = shifted[i];
      if (CntW'(i) >= base && rel < CntW'(push.cnt)) begin
        q_nxt[i] = push.res[rel[jsu_pkg::ResCntW-1:0]];
      end
    end
    cnt_nxt = base + CntW'(push.cnt);
  end

  // Hold queue count; payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(Depth))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != '0 |-> room)
    else $error("results pushed without room");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != '0 && !pop) |=> cnt_r == $past(cnt_r) + CntW'($past(push.cnt)))
    else $error("queue count lost results");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CntW'(1) && !$past(push.cnt != '0) && out_valid) |-> out_data.run_end ||
    $past(cnt_r) == CntW'(1))
    else $error("queue tail does not close its input byte");
`endif

endmodule

`default_nettype wire

FILE: src/json_string_unescaper.sv
// Top level of the JSON string unescaper: input register, escape decoder
// and result queue. Depends on jsu_pkg, jsu_decode and jsu_out_queue.
//
//   channel  ports                           payload          moves
//   in       in_valid, in_stall, in_data     jsu_pkg::in_t    one raw byte
//   out      out_valid, out_stall, out_data  jsu_pkg::out_t   one result
//
// A byte waits in the input register and is decoded in the cycle it leaves
// it, when its results enter the result queue; they show on out_data one per
// transfer. One byte per cycle is taken while each byte yields at most one
// result and out_stall stays low; a \u escape that yields two or three UTF-8
// bytes holds input until the single result port drains the queue. Reset
// (rst_n low, synchronous) empties the pipeline and returns the decoder to
// idle. out_stall backs up into in_stall once the result queue lacks room.
`default_nettype none

module json_string_unescaper (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire jsu_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output jsu_pkg::out_t      out_data
);

  jsu_pkg::in_t   in_r;
  logic           in_vld_r;
  logic           room;
  logic           step;
  jsu_pkg::push_t push;

  // Decode the held byte once the queue can take its results
  assign step     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;

  // Hold the input register while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
  end

  jsu_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_r),
    .push  (push)
  );

  jsu_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
